// ===== rtl/otcb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otcb_pkg: shared types and constants of the os tick counter bank
// register map, configuration bundle, queue item and the constant divisors
// used by the uptime pipeline
// ----------------------------------------------------------------------------
package otcb_pkg;

  localparam int NUM_COUNTERS = 2;
  localparam int CNT_SLOTS    = 2;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  localparam int PIPE_LEN = 11;

  localparam int PADDR_W = 5;

  localparam logic [29:0] RST_TICK_PERIOD = 30'd1000000;
  localparam logic [31:0] RST_DURATION    = 32'd1000000;
  localparam logic [31:0] RST_PER_BASE    = 32'd1;
  localparam logic [31:0] RST_MAX_VALUE   = 32'hFFFF_FFFF;

  localparam logic [31:0] USEC_LIMIT = 32'd1000000;
  localparam logic [31:0] TICK_DELTA = 32'd1;

  // 1e9 = 2^9 * 1953125
  localparam int          NS_SHIFT     = 9;
  localparam logic [20:0] NS_ODD_DIV   = 21'd1953125;
  localparam logic [32:0] RECIP_NS     = 33'((64'd1 << 53) / 64'd1953125);
  localparam logic [31:0] RECIP_NS_LO  = RECIP_NS[31:0];
  localparam logic        RECIP_NS_HI  = RECIP_NS[32];

  localparam logic [6:0]  SEC_PER_MIN  = 7'd60;
  localparam logic [5:0]  HOUR_PER_DAY = 6'd24;
  localparam logic [27:0] RECIP_60     = 28'((64'd1 << 33) / 64'd60);
  localparam logic [28:0] RECIP_24     = 29'((64'd1 << 33) / 64'd24);

  typedef enum logic [2:0] {
    REG_TICK_PERIOD = 3'd0,
    REG_C0_DURATION = 3'd1,
    REG_C0_PER_BASE = 3'd2,
    REG_C0_MAX      = 3'd3,
    REG_C1_DURATION = 3'd4,
    REG_C1_PER_BASE = 3'd5,
    REG_C1_MAX      = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [29:0]                 tick_period_ns;
    logic [CNT_SLOTS-1:0][31:0]  duration;
    logic [CNT_SLOTS-1:0][31:0]  per_base;
    logic [CNT_SLOTS-1:0][31:0]  max_value;
  } cfg_t;

  typedef struct packed {
    logic [31:0] ticks;
    logic [31:0] count_zero;
    logic [31:0] count_one;
  } entry_t;

endpackage

// ===== rtl/otcb_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otcb_regs: configuration register file
// apb-style write and read access to the tick period and counter settings
// ----------------------------------------------------------------------------
module otcb_regs
  import otcb_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cfg_t               cfg_o
);

  cfg_t     cfg_r;
  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_t'(paddr[4:2]);
  assign cfg_o  = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tick_period_ns <= RST_TICK_PERIOD;
      for (int i = 0; i < CNT_SLOTS; i++) begin
        cfg_r.duration[i]  <= RST_DURATION;
        cfg_r.per_base[i]  <= RST_PER_BASE;
        cfg_r.max_value[i] <= RST_MAX_VALUE;
      end
    end else if (wr_en) begin
      case (idx)
        REG_TICK_PERIOD: cfg_r.tick_period_ns <= pwdata[29:0];
        REG_C0_DURATION: cfg_r.duration[0]    <= pwdata;
        REG_C0_PER_BASE: cfg_r.per_base[0]    <= pwdata;
        REG_C0_MAX:      cfg_r.max_value[0]   <= pwdata;
        REG_C1_DURATION: cfg_r.duration[1]    <= pwdata;
        REG_C1_PER_BASE: cfg_r.per_base[1]    <= pwdata;
        REG_C1_MAX:      cfg_r.max_value[1]   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_TICK_PERIOD: prdata = {2'b00, cfg_r.tick_period_ns};
      REG_C0_DURATION: prdata = cfg_r.duration[0];
      REG_C0_PER_BASE: prdata = cfg_r.per_base[0];
      REG_C0_MAX:      prdata = cfg_r.max_value[0];
      REG_C1_DURATION: prdata = cfg_r.duration[1];
      REG_C1_PER_BASE: prdata = cfg_r.per_base[1];
      REG_C1_MAX:      prdata = cfg_r.max_value[1];
      default:         prdata = 32'd0;
    endcase
  end

endmodule

// ===== rtl/otcb_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otcb_front: tick intake and counter update
// advances the tick total, updates the counter bank and pushes one item
// per tick into the queue
// ----------------------------------------------------------------------------
module otcb_front
  import otcb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_usec_count,
  input  cfg_t        cfg_i,
  input  logic        q_full,
  output logic        push,
  output entry_t      push_data
);

  logic [31:0]                tick_r;
  logic [31:0]                last_usec_r;
  logic [CNT_SLOTS-1:0][31:0] cnt_r;
  logic [CNT_SLOTS-1:0][31:0] cnt_nxt;
  logic [31:0]                tick_nxt;
  logic [31:0]                d_usec;
  logic [31:0]                delta;
  logic [31:0]                sum;

  assign in_stall = q_full;
  assign push     = in_valid & ~q_full;
  assign tick_nxt = tick_r + 32'd1;
  assign d_usec   = in_usec_count - last_usec_r;

  // tick total advances by one; counter delta is d_usec under USEC_LIMIT, else one
  always_comb begin
    delta   = TICK_DELTA;
    sum     = 32'd0;
    cnt_nxt = cnt_r;
    for (int i = 0; i < NUM_COUNTERS; i++) begin
      delta = (cfg_i.duration[i] < USEC_LIMIT) ? d_usec : TICK_DELTA;
      sum   = cnt_r[i] + delta;
      if (delta >= cfg_i.per_base[i]) begin
        cnt_nxt[i] = (sum > cfg_i.max_value[i]) ? 32'd0 : sum;
      end
    end
  end

  assign push_data.ticks      = tick_nxt;
  assign push_data.count_zero = cnt_nxt[0];
  assign push_data.count_one  = cnt_nxt[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r      <= 32'd0;
      last_usec_r <= 32'd0;
      cnt_r       <= '0;
    end else if (push) begin
      tick_r      <= tick_nxt;
      last_usec_r <= in_usec_count;
      cnt_r       <= cnt_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_tick_step: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> (tick_r == $past(tick_r) + 32'd1))
    else $error("tick total did not advance by one");
`endif

endmodule

// ===== rtl/otcb_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otcb_queue: short item queue between front and back
// small flop fifo so that each side can stall on its own
// ----------------------------------------------------------------------------
module otcb_queue
  import otcb_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_data,
  input  logic   pop,
  output entry_t pop_data,
  output logic   full,
  output logic   empty
);

  entry_t          mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r;
  logic [Q_AW-1:0] rd_ptr_r;
  logic [Q_AW:0]   count_r;

  assign full     = (count_r == (Q_AW+1)'(Q_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (Q_AW+1)'(Q_DEPTH))
    else $error("queue count beyond depth");

  a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("pop from empty queue");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (full && !pop) |=> (count_r == $past(count_r)))
    else $error("queue count moved while full");
`endif

endmodule

// ===== rtl/otcb_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otcb_back: uptime pipeline and result register
// period times tick total, divide by 1e9 and split into days, hours,
// minutes and seconds by constant reciprocal multiplies with correction
// ----------------------------------------------------------------------------
module otcb_back
  import otcb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg_i,
  input  entry_t      q_data,
  input  logic        q_empty,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_ticks_now,
  output logic [31:0] out_count_zero,
  output logic [31:0] out_count_one,
  output logic [15:0] out_up_days,
  output logic [4:0]  out_up_hours,
  output logic [5:0]  out_up_minutes,
  output logic [5:0]  out_up_seconds,
  output logic        out_uptime_changed
);

  logic                en;
  logic [PIPE_LEN-1:0] vld_r;
  entry_t              ent_r [PIPE_LEN];
  logic [32:0]         last_up_r;

  logic [61:0] prod_s1_r;
  logic [52:0] x_s2_r;
  logic [63:0] pplo_s2_r;
  logic [52:0] pphi_s2_r;
  logic [52:0] x_s3_r;
  logic [32:0] q0_s3_r;
  logic [52:0] x_s4_r;
  logic [32:0] q_s4_r;
  logic [53:0] qd_s4_r;
  logic [32:0] up_s5_r;
  logic        chg_s5_r;
  logic [32:0] up_s6_r;
  logic [60:0] mul_s6_r;
  logic        chg_s6_r;
  logic [26:0] s_s7_r;
  logic [5:0]  sec_s7_r;
  logic        chg_s7_r;
  logic [26:0] s_s8_r;
  logic [54:0] mul_s8_r;
  logic [5:0]  sec_s8_r;
  logic        chg_s8_r;
  logic [20:0] m_s9_r;
  logic [5:0]  min_s9_r;
  logic [5:0]  sec_s9_r;
  logic        chg_s9_r;
  logic [20:0] m_s10_r;
  logic [49:0] mul_s10_r;
  logic [5:0]  min_s10_r;
  logic [5:0]  sec_s10_r;
  logic        chg_s10_r;
  logic [15:0] days_r;
  logic [4:0]  hours_r;
  logic [5:0]  min_r;
  logic [5:0]  sec_r;
  logic        chg_r;

  logic [61:0] prod_nxt;
  logic [52:0] x_nxt;
  logic [63:0] pplo_nxt;
  logic [52:0] pphi_nxt;
  logic [85:0] sum3;
  logic [53:0] qd_nxt;
  logic [52:0] rem5;
  logic [32:0] up_calc;
  logic        chg_calc;
  logic [60:0] mul6_nxt;
  logic [26:0] q7;
  logic [32:0] rem7;
  logic [26:0] s7_nxt;
  logic [5:0]  sec7_nxt;
  logic [54:0] mul8_nxt;
  logic [20:0] q9;
  logic [26:0] rem9;
  logic [20:0] m9_nxt;
  logic [5:0]  min9_nxt;
  logic [49:0] mul10_nxt;
  logic [16:0] q11;
  logic [20:0] rem11;
  logic [16:0] h11_nxt;
  logic [4:0]  hours11_nxt;

  assign en    = ~(vld_r[PIPE_LEN-1] & out_stall);
  assign q_pop = en & ~q_empty;

  always_comb begin
    prod_nxt  = cfg_i.tick_period_ns * q_data.ticks;
    x_nxt     = prod_s1_r[61:NS_SHIFT];
    pplo_nxt  = x_nxt[31:0] * RECIP_NS_LO;
    pphi_nxt  = x_nxt[52:32] * RECIP_NS_LO;
    sum3      = 86'(pplo_s2_r) + 86'({pphi_s2_r, 32'd0})
              + (RECIP_NS_HI ? 86'({x_s2_r, 32'd0}) : 86'd0);
    qd_nxt    = q0_s3_r * NS_ODD_DIV;
    rem5      = x_s4_r - qd_s4_r[52:0];
    up_calc   = (rem5 >= 53'(NS_ODD_DIV)) ? q_s4_r + 33'd1 : q_s4_r;
    chg_calc  = (up_calc != last_up_r);
    mul6_nxt  = up_s5_r * RECIP_60;

    // seconds
    q7   = mul_s6_r[59:33];
    rem7 = up_s6_r - (33'(q7) * 33'(SEC_PER_MIN));
    if (rem7[6:0] >= SEC_PER_MIN) begin
      s7_nxt   = q7 + 27'd1;
      sec7_nxt = 6'(rem7[6:0] - SEC_PER_MIN);
    end else begin
      s7_nxt   = q7;
      sec7_nxt = rem7[5:0];
    end
    mul8_nxt = s_s7_r * RECIP_60;

    // minutes
    q9   = mul_s8_r[53:33];
    rem9 = s_s8_r - (27'(q9) * 27'(SEC_PER_MIN));
    if (rem9[6:0] >= SEC_PER_MIN) begin
      m9_nxt   = q9 + 21'd1;
      min9_nxt = 6'(rem9[6:0] - SEC_PER_MIN);
    end else begin
      m9_nxt   = q9;
      min9_nxt = rem9[5:0];
    end
    mul10_nxt = m_s9_r * RECIP_24;

    // hours and days
    q11   = mul_s10_r[49:33];
    rem11 = m_s10_r - (21'(q11) * 21'(HOUR_PER_DAY));
    if (rem11[5:0] >= HOUR_PER_DAY) begin
      h11_nxt     = q11 + 17'd1;
      hours11_nxt = 5'(rem11[5:0] - HOUR_PER_DAY);
    end else begin
      h11_nxt     = q11;
      hours11_nxt = rem11[4:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      last_up_r <= 33'd0;
    end else if (en) begin
      vld_r <= {vld_r[PIPE_LEN-2:0], q_pop};
      if (vld_r[3] && chg_calc) begin
        last_up_r <= up_calc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ent_r[0] <= q_data;
      for (int i = 1; i < PIPE_LEN; i++) begin
        ent_r[i] <= ent_r[i-1];
      end
      prod_s1_r <= prod_nxt;
      x_s2_r    <= x_nxt;
      pplo_s2_r <= pplo_nxt;
      pphi_s2_r <= pphi_nxt;
      x_s3_r    <= x_s2_r;
      q0_s3_r   <= sum3[85:53];
      x_s4_r    <= x_s3_r;
      q_s4_r    <= q0_s3_r;
      qd_s4_r   <= qd_nxt;
      up_s5_r   <= up_calc;
      chg_s5_r  <= chg_calc;
      up_s6_r   <= up_s5_r;
      mul_s6_r  <= mul6_nxt;
      chg_s6_r  <= chg_s5_r;
      s_s7_r    <= s7_nxt;
      sec_s7_r  <= sec7_nxt;
      chg_s7_r  <= chg_s6_r;
      s_s8_r    <= s_s7_r;
      mul_s8_r  <= mul8_nxt;
      sec_s8_r  <= sec_s7_r;
      chg_s8_r  <= chg_s7_r;
      m_s9_r    <= m9_nxt;
      min_s9_r  <= min9_nxt;
      sec_s9_r  <= sec_s8_r;
      chg_s9_r  <= chg_s8_r;
      m_s10_r   <= m_s9_r;
      mul_s10_r <= mul10_nxt;
      min_s10_r <= min_s9_r;
      sec_s10_r <= sec_s9_r;
      chg_s10_r <= chg_s9_r;
      days_r    <= h11_nxt[15:0];
      hours_r   <= hours11_nxt;
      min_r     <= min_s10_r;
      sec_r     <= sec_s10_r;
      chg_r     <= chg_s10_r;
    end
  end

  assign out_valid          = vld_r[PIPE_LEN-1];
  assign out_ticks_now      = ent_r[PIPE_LEN-1].ticks;
  assign out_count_zero     = ent_r[PIPE_LEN-1].count_zero;
  assign out_count_one      = ent_r[PIPE_LEN-1].count_one;
  assign out_up_days        = days_r;
  assign out_up_hours       = hours_r;
  assign out_up_minutes     = min_r;
  assign out_up_seconds     = sec_r;
  assign out_uptime_changed = chg_r;

`ifndef ASSERT_OFF
  a_last_up_track: assert property (@(posedge clk) disable iff (!rst_n)
    (en && vld_r[3] && chg_calc) |=> (last_up_r == $past(up_calc)))
    else $error("last uptime not captured on change");
`endif

endmodule

// ===== rtl/os_tick_counter_bank_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// os_tick_counter_bank_core: os tick handler with counter bank and uptime
// front updates tick total and counters, a short queue decouples it from
// the uptime pipeline that produces the result item
// ----------------------------------------------------------------------------
// The block takes one tick item per clock while in_stall is low and returns
// one result item per tick, in order. The front updates the tick total and
// both counters in the cycle of acceptance; the uptime breakdown then runs
// through an eleven stage pipeline of constant reciprocal multiplies. A four
// item queue sits between front and pipeline; a stalled output freezes the
// pipeline and in_stall rises once the queue is full. Configuration must be
// written through the apb port only while no item is in flight; the block
// itself does not enforce this.
module os_tick_counter_bank_core
  import otcb_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [31:0]        in_usec_count,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        out_ticks_now,
  output logic [31:0]        out_count_zero,
  output logic [31:0]        out_count_one,
  output logic [15:0]        out_up_days,
  output logic [4:0]         out_up_hours,
  output logic [5:0]         out_up_minutes,
  output logic [5:0]         out_up_seconds,
  output logic               out_uptime_changed,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t   cfg;
  logic   q_full;
  logic   q_empty;
  logic   q_push;
  logic   q_pop;
  entry_t q_wdata;
  entry_t q_rdata;

  otcb_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  otcb_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_usec_count (in_usec_count),
    .cfg_i         (cfg),
    .q_full        (q_full),
    .push          (q_push),
    .push_data     (q_wdata)
  );

  otcb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .full      (q_full),
    .empty     (q_empty)
  );

  otcb_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_i              (cfg),
    .q_data             (q_rdata),
    .q_empty            (q_empty),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_ticks_now      (out_ticks_now),
    .out_count_zero     (out_count_zero),
    .out_count_one      (out_count_one),
    .out_up_days        (out_up_days),
    .out_up_hours       (out_up_hours),
    .out_up_minutes     (out_up_minutes),
    .out_up_seconds     (out_up_seconds),
    .out_uptime_changed (out_uptime_changed)
  );

endmodule
